// ----- sv/u29_pkg.sv -----
`timescale 1ns / 1ps

package u29_pkg;

    // Operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_ENC_U = 2'd0,
        OP_ENC_S = 2'd1,
        OP_DEC_U = 2'd2,
        OP_DEC_S = 2'd3
    } t_op;

    // Kind of work queued between front and back
    typedef enum logic [1:0] {
        KIND_ENC = 2'd0,
        KIND_ERR = 2'd1,
        KIND_VAL = 2'd2
    } t_kind;

    // One queued command.
    // KIND_ENC: data holds the encoded bytes, first byte in [31:24];
    //           last_idx is the index of the final byte.
    // KIND_VAL: data holds the decoded value.
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  last_idx;
        logic [31:0] data;
    } t_cmd;

endpackage

// ----- sv/u29_in_if.sv -----
`timescale 1ns / 1ps

interface u29_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] value_word;
    logic [7:0]  byte_in;

    modport source (output valid, output operation, output value_word, output byte_in,
                    input ready);
    modport sink   (input valid, input operation, input value_word, input byte_in,
                    output ready);
endinterface

// ----- sv/u29_out_if.sv -----
`timescale 1ns / 1ps

interface u29_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic        byte_valid;
    logic        last;
    logic [31:0] value_out;
    logic        value_valid;
    logic        error_flag;

    modport source (output valid, output byte_out, output byte_valid, output last,
                    output value_out, output value_valid, output error_flag,
                    input ready);
    modport sink   (input valid, input byte_out, input byte_valid, input last,
                    input value_out, input value_valid, input error_flag,
                    output ready);
endinterface

// ----- sv/u29_front.sv -----
`timescale 1ns / 1ps

module u29_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    u29_in_if.sink           i_in,
    input  logic             i_full,
    output logic             o_push,
    output u29_pkg::t_cmd    o_cmd
);

    logic [1:0]  r_pos;
    logic [28:0] r_acc;
    logic [1:0]  n_pos;
    logic [28:0] n_acc;

    logic        accept;
    logic [28:0] enc_v;
    logic        enc_err;
    logic [28:0] dec_acc;
    logic        dec_done;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign enc_v      = i_in.value_word[28:0];

    // Continuation groups carry 7 bits; the fourth byte carries 8
    always_comb begin
        if (r_pos == 2'd3) begin
            dec_acc  = {r_acc[20:0], i_in.byte_in};
            dec_done = 1'b1;
        end else begin
            dec_acc  = {r_acc[21:0], i_in.byte_in[6:0]};
            dec_done = !i_in.byte_in[7];
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_acc   = r_acc;
        o_push  = 1'b0;
        enc_err = 1'b0;
        o_cmd   = '{kind: u29_pkg::KIND_ERR, last_idx: 2'd0, data: 32'd0};

        unique case (u29_pkg::t_op'(i_in.operation))
            u29_pkg::OP_ENC_U, u29_pkg::OP_ENC_S: begin
                if (u29_pkg::t_op'(i_in.operation) == u29_pkg::OP_ENC_U) begin
                    enc_err = i_in.value_word[31:29] != 3'd0;
                end else begin
                    enc_err = i_in.value_word[31:28] != {4{i_in.value_word[28]}};
                end
                o_push = accept;
                if (!enc_err) begin
                    o_cmd.kind = u29_pkg::KIND_ENC;
                    if (enc_v[28:7] == 22'd0) begin
                        o_cmd.last_idx = 2'd0;
                        o_cmd.data     = {1'b0, enc_v[6:0], 24'd0};
                    end else if (enc_v[28:14] == 15'd0) begin
                        o_cmd.last_idx = 2'd1;
                        o_cmd.data     = {1'b1, enc_v[13:7], 1'b0, enc_v[6:0], 16'd0};
                    end else if (enc_v[28:21] == 8'd0) begin
                        o_cmd.last_idx = 2'd2;
                        o_cmd.data     = {1'b1, enc_v[20:14], 1'b1, enc_v[13:7],
                                          1'b0, enc_v[6:0], 8'd0};
                    end else begin
                        o_cmd.last_idx = 2'd3;
                        o_cmd.data     = {1'b1, enc_v[28:22], 1'b1, enc_v[21:15],
                                          1'b1, enc_v[14:8], enc_v[7:0]};
                    end
                end
            end
            u29_pkg::OP_DEC_U, u29_pkg::OP_DEC_S: begin
                if (accept) begin
                    if (dec_done) begin
                        o_push     = 1'b1;
                        n_pos      = 2'd0;
                        n_acc      = 29'd0;
                    end else begin
                        n_pos      = r_pos + 2'd1;
                        n_acc      = dec_acc;
                    end
                end
                o_cmd.kind = u29_pkg::KIND_VAL;
                // Signed mode sets bits 31:29 when bit 28 is set
                o_cmd.data = {{3{dec_acc[28] &&
                                 (u29_pkg::t_op'(i_in.operation) == u29_pkg::OP_DEC_S)}},
                              dec_acc};
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
            r_acc <= 29'd0;
        end else begin
            r_pos <= n_pos;
            r_acc <= n_acc;
        end
    end

endmodule

// ----- sv/u29_fifo.sv -----
`timescale 1ns / 1ps

module u29_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u29_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output u29_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u29_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ----- sv/u29_back.sv -----
`timescale 1ns / 1ps

module u29_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  u29_pkg::t_cmd i_head,
    output logic          o_pop,
    u29_out_if.source     o_out
);

    logic        r_valid;
    logic [1:0]  r_idx;
    logic [7:0]  r_byte;
    logic        r_byte_valid;
    logic        r_last;
    logic [31:0] r_value;
    logic        r_value_valid;
    logic        r_error;

    logic        n_valid;
    logic [1:0]  n_idx;
    logic [7:0]  n_byte;
    logic        n_byte_valid;
    logic        n_last;
    logic [31:0] n_value;
    logic        n_value_valid;
    logic        n_error;

    logic        load;
    logic [7:0]  sel_byte;

    assign load = !r_valid || o_out.ready;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.data[31:24];
            2'd1:    sel_byte = i_head.data[23:16];
            2'd2:    sel_byte = i_head.data[15:8];
            default: sel_byte = i_head.data[7:0];
        endcase
    end

    always_comb begin
        n_valid       = r_valid;
        n_idx         = r_idx;
        n_byte        = r_byte;
        n_byte_valid  = r_byte_valid;
        n_last        = r_last;
        n_value       = r_value;
        n_value_valid = r_value_valid;
        n_error       = r_error;
        o_pop         = 1'b0;

        if (load) begin
            n_valid       = i_head_valid;
            n_byte        = 8'd0;
            n_byte_valid  = 1'b0;
            n_last        = 1'b0;
            n_value       = 32'd0;
            n_value_valid = 1'b0;
            n_error       = 1'b0;
            if (i_head_valid) begin
                unique case (i_head.kind)
                    u29_pkg::KIND_ENC: begin
                        n_byte       = sel_byte;
                        n_byte_valid = 1'b1;
                        n_last       = r_idx == i_head.last_idx;
                        if (r_idx == i_head.last_idx) begin
                            o_pop = 1'b1;
                            n_idx = 2'd0;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end
                    u29_pkg::KIND_ERR: begin
                        n_error = 1'b1;
                        n_last  = 1'b1;
                        o_pop   = 1'b1;
                    end
                    u29_pkg::KIND_VAL: begin
                        n_value       = i_head.data;
                        n_value_valid = 1'b1;
                        n_last        = 1'b1;
                        o_pop         = 1'b1;
                    end
                    default: begin
                        n_valid = 1'b0;
                        o_pop   = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte        <= n_byte;
        r_byte_valid  <= n_byte_valid;
        r_last        <= n_last;
        r_value       <= n_value;
        r_value_valid <= n_value_valid;
        r_error       <= n_error;
    end

    assign o_out.valid       = r_valid;
    assign o_out.byte_out    = r_byte;
    assign o_out.byte_valid  = r_byte_valid;
    assign o_out.last        = r_last;
    assign o_out.value_out   = r_value;
    assign o_out.value_valid = r_value_valid;
    assign o_out.error_flag  = r_error;

endmodule

// ----- sv/u29_varint_codec.sv -----
`timescale 1ns / 1ps
// Channel  | Dir | Handshake    | Payload
// ---------+-----+--------------+-----------------------------------------------
// i_in     | in  | valid/ready  | operation[1:0], value_word[31:0], byte_in[7:0]
// o_out    | out | valid/ready  | byte_out[7:0], byte_valid, last, value_out[31:0],
//          |     |              | value_valid, error_flag
//
// Flow: the input side takes one transaction per cycle while the command
// queue has room. The output register gives one result per cycle while
// o_out.ready is high: an encode gives one result per byte (1 to 4), an
// error or a finished decode one, a continuation byte none. Sustained rate
// is set by the byte-wide output port, one result per encoded byte.
// Path: a command is written into the queue, then loaded into the output register.
// Reset: synchronous, active low; clears queue pointers, decode state and the
// output valid. Stalls: o_out.ready low holds the result; input keeps flowing
// until QUEUE_DEPTH commands are waiting.

module u29_varint_codec #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u29_in_if.sink    i_in,
    u29_out_if.source o_out
);

    // Front: classification, range check, byte packing and decode accumulation
    logic          push;
    u29_pkg::t_cmd push_cmd;
    logic          full;

    // Back: drains commands, one result per cycle while o_out.ready is high
    logic          head_valid;
    u29_pkg::t_cmd head_cmd;
    logic          pop;

    u29_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Decouples acceptance from multi-byte emission
    u29_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    u29_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ----- sv/u29_checker.sv -----
`timescale 1ns / 1ps

module u29_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [7:0]  i_byte_out,
    input logic        i_byte_valid,
    input logic        i_last,
    input logic [31:0] i_value_out,
    input logic        i_value_valid,
    input logic        i_error_flag
);

    // Every result is exactly one of byte, value or error
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> $onehot({i_byte_valid, i_value_valid, i_error_flag}))
        else $error("result carries not exactly one kind");

    // Value and error results end their transaction
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_value_valid || i_error_flag) |-> i_last)
        else $error("value or error result without last");

    // Fields of other kinds read as zero
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_byte_valid || i_byte_out == 8'd0) &&
                     (i_value_valid || i_value_out == 32'd0)))
        else $error("unused result field not zero");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_byte_out) && $stable(i_last) &&
                                $stable(i_value_out) && $stable(i_error_flag))
        else $error("stalled result changed");

endmodule

bind u29_varint_codec u29_checker u_u29_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_byte_out    (o_out.byte_out),
    .i_byte_valid  (o_out.byte_valid),
    .i_last        (o_out.last),
    .i_value_out   (o_out.value_out),
    .i_value_valid (o_out.value_valid),
    .i_error_flag  (o_out.error_flag)
);
